FILE: hdl/clr_pkg.sv
// Shared types and constants for the clipped line rasterizer.
// No dependencies; compiled first.
`default_nettype none

package clr_pkg;

   // Field widths fixed by the channel definitions
   localparam int COORD_W   = 16;
   localparam int PIXEL_W   = 6;
   localparam int DIM_W     = 7;
   localparam int CSR_IDX_W = 1;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   // Reset value of both rectangle registers
   localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

   // Outcode bits
   localparam logic [3:0] OC_LEFT   = 4'b0001;
   localparam logic [3:0] OC_RIGHT  = 4'b0010;
   localparam logic [3:0] OC_BOTTOM = 4'b0100;
   localparam logic [3:0] OC_TOP    = 4'b1000;

   // Clip steps allowed before a segment is dropped
   localparam logic [3:0] MAX_CLIP_STEPS = 4'd8;

   // Divider: quotient bits produced, one per cycle
   localparam int QUO_W = 18;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLIP,
      ST_MUL_AD,
      ST_MUL_BM,
      ST_DIV_PREP,
      ST_DIV,
      ST_UPDATE,
      ST_WALK_PREP,
      ST_WALK
   } clr_state_type;

endpackage

`default_nettype wire

FILE: hdl/clr_req_if.sv
// Line segment request channel: valid/ready handshake with two endpoints.
// Depends on clr_pkg for the coordinate width.
`default_nettype none

interface clr_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [clr_pkg::COORD_W-1:0]  start_x;
   logic signed [clr_pkg::COORD_W-1:0]  start_y;
   logic signed [clr_pkg::COORD_W-1:0]  end_x;
   logic signed [clr_pkg::COORD_W-1:0]  end_y;

   modport source (output valid, start_x, start_y, end_x, end_y, input ready);
   modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

`default_nettype wire

FILE: hdl/clr_rsp_if.sv
// Pixel response channel: valid/ready handshake, one pixel per beat.
// Depends on clr_pkg for the pixel width.
`default_nettype none

interface clr_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [clr_pkg::PIXEL_W-1:0]  pixel_x;
   logic [clr_pkg::PIXEL_W-1:0]  pixel_y;
   logic                         last;

   modport source (output valid, pixel_x, pixel_y, last, input ready);
   modport sink   (input valid, pixel_x, pixel_y, last, output ready);
endinterface

`default_nettype wire

FILE: hdl/clipped_line_rasterizer.sv
// Top level of the clipped line rasterizer: clip sequencer, shared
// multiplier and divider, line walker. Uses clr_pkg, clr_req_if, clr_rsp_if.
`default_nettype none

// Usage
//   req_chan carries one segment per beat (two signed 16-bit endpoints).
//   rsp_chan returns the pixels of the segment after clipping to the
//   rectangle 0..image_width-1 by 0..image_height-1, each side clamped to
//   MAX_DIM, last set on the final pixel. A segment fully outside gives no beats.
//   csr_* writes image_width (index 0) or image_height (index 1); write only
//   while no segment is in flight.
// Timing
//   req_chan.ready is high only in the idle state; one segment at a time.
//   Each clip step runs through the shared 18x18 multiplier (a*d, then
//   b*(edge - ref)) and the restoring divider (one quotient bit per cycle),
//   besides the outcode test, setup and write-back of the step.
//   A segment takes k clip steps (0 to 4 for real geometry) and gives n pixels
//   (at most 64), the walker giving one pixel a cycle while rsp_chan is not stalled.
// Reset and stall
//   Reset returns to idle, drops any pending beat and sets both rectangle
//   registers to 64. A stalled rsp_chan holds its beat; the walker waits
//   for the output register to free before it advances.

module clipped_line_rasterizer #(
   parameter int MAX_DIM = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   clr_req_if.sink                                 req_chan,
   clr_rsp_if.source                               rsp_chan,
   input  wire logic                               csr_write_enable,
   input  wire logic [clr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [clr_pkg::DIM_W-1:0]          csr_write_data
);
   import clr_pkg::*;

   localparam logic [DIM_W-1:0] MaxDim = DIM_W'(MAX_DIM);

   // ---------------- registers ----------------
   clr_state_type      state_ff, state_in;
   logic [DIM_W-1:0]   width_ff, width_in;
   logic [DIM_W-1:0]   height_ff, height_in;

   logic signed [16:0] x0_ff, x0_in, y0_ff, y0_in;
   logic signed [16:0] x1_ff, x1_in, y1_ff, y1_in;
   logic [3:0]         step_ff, step_in;

   logic signed [17:0] op_a_ff, op_a_in, op_b_ff, op_b_in;
   logic signed [17:0] op_m_ff, op_m_in, op_d_ff, op_d_in;
   logic               vert_ff, vert_in;
   logic               side_ff, side_in;
   logic signed [16:0] edge_val_ff, edge_val_in;

   logic signed [36:0] num_ff, num_in;
   logic [36:0]        rem_ff, rem_in;
   logic [34:0]        dsh_ff, dsh_in;
   logic [QUO_W-1:0]   quo_ff, quo_in;
   logic               neg_ff, neg_in;
   logic [4:0]         bit_cnt_ff, bit_cnt_in;

   logic [PIXEL_W-1:0] px_ff, px_in, py_ff, py_in;
   logic [PIXEL_W-1:0] tx_ff, tx_in, ty_ff, ty_in;
   logic [PIXEL_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic               sx_neg_ff, sx_neg_in, sy_neg_ff, sy_neg_in;
   logic signed [8:0]  err_ff, err_in;
   logic [PIXEL_W-1:0] pix_cnt_ff, pix_cnt_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic               rsp_last_ff, rsp_last_in;

   // ---------------- helpers ----------------
   function automatic logic [3:0] outcode(input logic signed [16:0] x,
                                          input logic signed [16:0] y,
                                          input logic [DIM_W-1:0]   w,
                                          input logic [DIM_W-1:0]   h);
      logic [3:0] c;
      c = '0;
      if (x < 0) c |= OC_LEFT;
      else if (x >= signed'({10'b0, w})) c |= OC_RIGHT;
      if (y < 0) c |= OC_BOTTOM;
      else if (y >= signed'({10'b0, h})) c |= OC_TOP;
      return c;
   endfunction

   function automatic logic signed [17:0] sub18(input logic signed [16:0] p,
                                                input logic signed [16:0] q);
      return signed'({p[16], p}) - signed'({q[16], q});
   endfunction

   // ---------------- combinational datapath pieces ----------------
   logic [DIM_W-1:0]   w_eff, h_eff;
   logic signed [16:0] xmax, ymax;
   logic [3:0]         oc0, oc1, oc_out;
   logic signed [17:0] mul_x, mul_y;
   logic signed [35:0] product;
   logic [37:0]        trial;
   logic               trial_ge;
   logic [QUO_W-1:0]   quo_signed;
   logic signed [16:0] clip_res;
   logic signed [17:0] abs_d;
   logic               out_free;
   logic               walk_done;
   logic signed [9:0]  e2, err_wide;
   logic               step_x, step_y;

   // Clamp the rectangle to what the pixel fields can address
   assign w_eff = (width_ff > MaxDim) ? MaxDim : width_ff;
   assign h_eff = (height_ff > MaxDim) ? MaxDim : height_ff;
   assign xmax  = signed'({10'b0, w_eff - 7'd1});
   assign ymax  = signed'({10'b0, h_eff - 7'd1});

   assign oc0    = outcode(x0_ff, y0_ff, w_eff, h_eff);
   assign oc1    = outcode(x1_ff, y1_ff, w_eff, h_eff);
   assign oc_out = (oc0 != 4'b0) ? oc0 : oc1;

   // Shared multiplier: a*d first, then b*(edge - ref)
   assign mul_x   = (state_ff == ST_MUL_AD) ? op_a_ff : op_b_ff;
   assign mul_y   = (state_ff == ST_MUL_AD) ? op_d_ff : op_m_ff;
   assign product = mul_x * mul_y;

   // Restoring divider step
   assign trial    = {1'b0, rem_ff} - {3'b0, dsh_ff};
   assign trial_ge = ~trial[37];
   assign abs_d    = op_d_ff[17] ? -op_d_ff : op_d_ff;

   // Signed quotient, truncated toward zero; a flat edge keeps the start value
   assign quo_signed = neg_ff ? (QUO_W'(0) - quo_ff) : quo_ff;
   assign clip_res   = (op_d_ff == 18'sd0) ? op_a_ff[16:0] : signed'(quo_signed[16:0]);

   // Bresenham decision terms
   assign out_free  = ~rsp_valid_ff | rsp_chan.ready;
   assign walk_done = ((px_ff == tx_ff) && (py_ff == ty_ff)) || (pix_cnt_ff == 6'd63);
   assign e2        = signed'({err_ff, 1'b0});
   assign step_x    = e2 > -signed'({4'b0, dy_ff});
   assign step_y    = e2 < signed'({4'b0, dx_ff});
   assign err_wide  = signed'({err_ff[8], err_ff})
                      - (step_x ? signed'({4'b0, dy_ff}) : 10'sd0)
                      + (step_y ? signed'({4'b0, dx_ff}) : 10'sd0);

   // ---------------- sequencer ----------------
   always_comb begin
      state_in     = state_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      x0_in        = x0_ff;
      y0_in        = y0_ff;
      x1_in        = x1_ff;
      y1_in        = y1_ff;
      step_in      = step_ff;
      op_a_in      = op_a_ff;
      op_b_in      = op_b_ff;
      op_m_in      = op_m_ff;
      op_d_in      = op_d_ff;
      vert_in      = vert_ff;
      side_in      = side_ff;
      edge_val_in  = edge_val_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      dsh_in       = dsh_ff;
      quo_in       = quo_ff;
      neg_in       = neg_ff;
      bit_cnt_in   = bit_cnt_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      tx_in        = tx_ff;
      ty_in        = ty_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      sx_neg_in    = sx_neg_ff;
      sy_neg_in    = sy_neg_ff;
      err_in       = err_ff;
      pix_cnt_in   = pix_cnt_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_last_in  = rsp_last_ff;
      // drop the pending beat once taken
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;

      // configuration writes
      if (csr_write_enable) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_write_data;
            CSR_IMAGE_HEIGHT: height_in = csr_write_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               x0_in    = 17'(req_chan.start_x);
               y0_in    = 17'(req_chan.start_y);
               x1_in    = 17'(req_chan.end_x);
               y1_in    = 17'(req_chan.end_y);
               step_in  = '0;
               state_in = ST_CLIP;
            end
         end

         // Decide accept or reject, else set up one edge intersection
         ST_CLIP: begin
            if ((w_eff == 7'd0) || (h_eff == 7'd0)) begin
               state_in = ST_IDLE;
            end else if ((oc0 | oc1) == 4'b0) begin
               state_in = ST_WALK_PREP;
            end else if (((oc0 & oc1) != 4'b0) || (step_ff == MAX_CLIP_STEPS)) begin
               state_in = ST_IDLE;
            end else begin
               side_in = (oc0 == 4'b0);
               if ((oc_out & (OC_TOP | OC_BOTTOM)) != 4'b0) begin
                  vert_in     = 1'b1;
                  edge_val_in = ((oc_out & OC_TOP) != 4'b0) ? ymax : 17'sd0;
                  op_a_in     = signed'({x0_ff[16], x0_ff});
                  op_b_in     = sub18(x1_ff, x0_ff);
                  op_d_in     = sub18(y1_ff, y0_ff);
                  op_m_in     = sub18(edge_val_in, y0_ff);
               end else begin
                  vert_in     = 1'b0;
                  edge_val_in = ((oc_out & OC_RIGHT) != 4'b0) ? xmax : 17'sd0;
                  op_a_in     = signed'({y0_ff[16], y0_ff});
                  op_b_in     = sub18(y1_ff, y0_ff);
                  op_d_in     = sub18(x1_ff, x0_ff);
                  op_m_in     = sub18(edge_val_in, x0_ff);
               end
               state_in = ST_MUL_AD;
            end
         end

         ST_MUL_AD: begin
            num_in   = 37'(product);
            state_in = ST_MUL_BM;
         end

         ST_MUL_BM: begin
            num_in   = num_ff + 37'(product);
            state_in = ST_DIV_PREP;
         end

         // Divide magnitudes; divisor starts aligned to the top quotient bit
         ST_DIV_PREP: begin
            neg_in     = num_ff[36] ^ op_d_ff[17];
            rem_in     = num_ff[36] ? 37'(-num_ff) : 37'(num_ff);
            dsh_in     = {abs_d[16:0], 18'b0} >> 1;
            quo_in     = '0;
            bit_cnt_in = 5'(QUO_W - 1);
            state_in   = ST_DIV;
         end

         ST_DIV: begin
            if (trial_ge) rem_in = trial[36:0];
            quo_in     = {quo_ff[QUO_W-2:0], trial_ge};
            dsh_in     = dsh_ff >> 1;
            bit_cnt_in = bit_cnt_ff - 5'd1;
            if (bit_cnt_ff == 5'd0) state_in = ST_UPDATE;
         end

         // Move the outside endpoint onto the edge
         ST_UPDATE: begin
            if (side_ff) begin
               x1_in = vert_ff ? clip_res : edge_val_ff;
               y1_in = vert_ff ? edge_val_ff : clip_res;
            end else begin
               x0_in = vert_ff ? clip_res : edge_val_ff;
               y0_in = vert_ff ? edge_val_ff : clip_res;
            end
            step_in  = step_ff + 4'd1;
            state_in = ST_CLIP;
         end

         // Both endpoints are inside: load the walker
         ST_WALK_PREP: begin
            px_in      = x0_ff[PIXEL_W-1:0];
            py_in      = y0_ff[PIXEL_W-1:0];
            tx_in      = x1_ff[PIXEL_W-1:0];
            ty_in      = y1_ff[PIXEL_W-1:0];
            dx_in      = (x1_ff > x0_ff) ? (tx_in - px_in) : (px_in - tx_in);
            dy_in      = (y1_ff > y0_ff) ? (ty_in - py_in) : (py_in - ty_in);
            sx_neg_in  = ~(x0_ff < x1_ff);
            sy_neg_in  = ~(y0_ff < y1_ff);
            err_in     = signed'({3'b0, dx_in}) - signed'({3'b0, dy_in});
            pix_cnt_in = '0;
            state_in   = ST_WALK;
         end

         // One pixel per cycle whenever the output register can take it
         ST_WALK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = px_ff;
               rsp_y_in     = py_ff;
               rsp_last_in  = walk_done;
               if (walk_done) begin
                  state_in = ST_IDLE;
               end else begin
                  err_in     = err_wide[8:0];
                  pix_cnt_in = pix_cnt_ff + 6'd1;
                  if (step_x) px_in = sx_neg_ff ? px_ff - 6'd1 : px_ff + 6'd1;
                  if (step_y) py_in = sy_neg_ff ? py_ff - 6'd1 : py_ff + 6'd1;
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= DIM_RESET;
         height_ff    <= DIM_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------- payload registers ----------------
   always_ff @(posedge clock) begin
      x0_ff       <= x0_in;
      y0_ff       <= y0_in;
      x1_ff       <= x1_in;
      y1_ff       <= y1_in;
      step_ff     <= step_in;
      op_a_ff     <= op_a_in;
      op_b_ff     <= op_b_in;
      op_m_ff     <= op_m_in;
      op_d_ff     <= op_d_in;
      vert_ff     <= vert_in;
      side_ff     <= side_in;
      edge_val_ff <= edge_val_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      dsh_ff      <= dsh_in;
      quo_ff      <= quo_in;
      neg_ff      <= neg_in;
      bit_cnt_ff  <= bit_cnt_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      tx_ff       <= tx_in;
      ty_ff       <= ty_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      sx_neg_ff   <= sx_neg_in;
      sy_neg_ff   <= sy_neg_in;
      err_ff      <= err_in;
      pix_cnt_ff  <= pix_cnt_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_last_ff <= rsp_last_in;
   end

   // ---------------- ports ----------------
   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.pixel_x = rsp_x_ff;
   assign rsp_chan.pixel_y = rsp_y_ff;
   assign rsp_chan.last    = rsp_last_ff;

endmodule

`default_nettype wire

FILE: hdl/clr_checker.sv
// Port-level checks for the clipped line rasterizer, bound to the top level.
// Depends on clr_pkg and on clipped_line_rasterizer for the bind.
`default_nettype none

module clr_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic [clr_pkg::PIXEL_W-1:0]    pixel_x,
   input wire logic [clr_pkg::PIXEL_W-1:0]    pixel_y,
   input wire logic                           last,
   input wire logic                           csr_write_enable,
   input wire logic [clr_pkg::CSR_IDX_W-1:0]  csr_index,
   input wire logic [clr_pkg::DIM_W-1:0]      csr_write_data
);
   import clr_pkg::*;

   logic [DIM_W-1:0]   width_ff, height_ff;
   logic               in_line_ff;
   logic [PIXEL_W-1:0] prev_x_ff, prev_y_ff;
   logic [PIXEL_W-1:0] diff_x, diff_y;

   // Track the rectangle and the previous pixel of the current line
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= DIM_RESET;
         height_ff  <= DIM_RESET;
         in_line_ff <= 1'b0;
      end else begin
         if (csr_write_enable && (csr_index == CSR_IMAGE_WIDTH)) width_ff <= csr_write_data;
         if (csr_write_enable && (csr_index == CSR_IMAGE_HEIGHT)) height_ff <= csr_write_data;
         if (rsp_valid && rsp_ready) in_line_ff <= ~last;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         prev_x_ff <= pixel_x;
         prev_y_ff <= pixel_y;
      end
   end

   assign diff_x = pixel_x - prev_x_ff;
   assign diff_y = pixel_y - prev_y_ff;

   // A stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(pixel_x) && $stable(pixel_y)
                                     && $stable(last)))
      else $error("rsp beat changed while stalled");

   // Reset drops any pending beat
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // Every pixel lies inside the configured rectangle
   a_in_rect: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (({1'b0, pixel_x} < width_ff) && ({1'b0, pixel_y} < height_ff)))
      else $error("pixel outside the clip rectangle");

   // Consecutive pixels of one line are 8-connected and never the same
   a_adjacent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && in_line_ff) |->
         ((diff_x == 6'd0 || diff_x == 6'd1 || diff_x == 6'h3F)
          && (diff_y == 6'd0 || diff_y == 6'd1 || diff_y == 6'h3F)
          && !(diff_x == 6'd0 && diff_y == 6'd0)))
      else $error("line pixels not adjacent");

endmodule

bind clipped_line_rasterizer clr_checker u_clr_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .pixel_x          (rsp_chan.pixel_x),
   .pixel_y          (rsp_chan.pixel_y),
   .last             (rsp_chan.last),
   .csr_write_enable (csr_write_enable),
   .csr_index        (csr_index),
   .csr_write_data   (csr_write_data)
);

`default_nettype wire
